// ===== src/sidta_pkg.sv =====
// ----------------------------------------------------------------------------
// sidta_pkg
// Shared types and constants for the signed integer to decimal text core.
// ----------------------------------------------------------------------------
`default_nettype none

package sidta_pkg;

  localparam int CHAR_W = 7;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic conv;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_last;
    logic top_zero;
    logic one_left;
    logic negative;
    logic slot_free;
  } status_t;

endpackage

`default_nettype wire

// ===== src/sidta_ctrl.sv =====
// ----------------------------------------------------------------------------
// sidta_ctrl
// Sequencer: accept, binary to BCD conversion, leading zero skip, emission.
// ----------------------------------------------------------------------------
`default_nettype none

module sidta_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  sidta_pkg::status_t  status,
  output sidta_pkg::cmd_t     cmd
);
  import sidta_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (status.conv_last) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zero digits, but always keep the final one.
        if (status.top_zero && !status.one_left) begin
          cmd.skip = 1'b1;
        end else if (status.negative) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (status.slot_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.slot_free) begin
          cmd.emit_digit = 1'b1;
          if (status.one_left) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/sidta_datapath.sv =====
// ----------------------------------------------------------------------------
// sidta_datapath
// Magnitude register, shift-and-add-3 BCD converter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sidta_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire signed [VALUE_BITS-1:0]         in_value,
  input  sidta_pkg::cmd_t                     cmd,
  output sidta_pkg::status_t                  status,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [sidta_pkg::CHAR_W-1:0]        out_character,
  output logic                                out_last
);
  import sidta_pkg::*;

  // Decimal digits needed for any magnitude of VALUE_BITS bits.
  localparam int NDIG   = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W  = NDIG * 4;
  localparam int CNT_W  = $clog2(VALUE_BITS);
  localparam int LEFT_W = $clog2(NDIG + 1);
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(VALUE_BITS - 1);
  localparam logic [LEFT_W-1:0] LEFT_ALL = LEFT_W'(NDIG);
  localparam logic [LEFT_W-1:0] LEFT_ONE = LEFT_W'(1);

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [BCD_W-1:0]      bcd_adj;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [LEFT_W-1:0]     left_r, left_nxt;
  logic                  neg_r, neg_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [3:0]            top_digit;

  assign top_digit = bcd_r[BCD_W-1 -: 4];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (cmd.load) begin
      // Negation in unsigned arithmetic gives the right magnitude even for
      // the most negative value.
      neg_nxt  = in_value[VALUE_BITS-1];
      mag_nxt  = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      left_nxt = LEFT_ALL;
    end
    if (cmd.conv) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
      mag_nxt = {mag_r[VALUE_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.skip || cmd.emit_digit) begin
      bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
      left_nxt = left_r - 1'b1;
    end
    if (cmd.emit_sign) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_MINUS;
      out_last_nxt  = 1'b0;
    end
    if (cmd.emit_digit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_ZERO + {3'd0, top_digit};
      out_last_nxt  = (left_r == LEFT_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      left_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      left_r      <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign status.conv_last = (cnt_r == CNT_LAST);
  assign status.top_zero  = (top_digit == 4'd0);
  assign status.one_left  = (left_r == LEFT_ONE);
  assign status.negative  = neg_r;
  assign status.slot_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

// ===== src/signed_int_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed integer to its decimal ASCII text, one character per
// output handshake, most significant first, with the last character flagged.
// ----------------------------------------------------------------------------
// The core accepts a new value only in its idle state, once the last character
// of the previous value has entered the output register. The shift-and-add-3
// converter takes one input bit a cycle, then the BCD register is shifted one
// digit a cycle to drop leading zeros and, while the output slot is free, to
// emit characters. The first character appears later for shorter texts, as
// more leading zeros are skipped first. Reset clears the sequencer and the
// output valid flag; no data is kept.
`default_nettype none

module signed_int_to_decimal_ascii_core #(
  parameter int VALUE_BITS = 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire signed [VALUE_BITS-1:0]         in_value,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [sidta_pkg::CHAR_W-1:0]        out_character,
  output logic                                out_last
);
  import sidta_pkg::*;

  cmd_t    cmd;
  status_t status;

  sidta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sidta_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the signed integer to decimal text core. Every accepted value is
// turned into its expected character run in the testbench, and each output
// character is compared in order against it. A directed set covers the
// extremes, zero and the digit-count boundaries. A random set follows, with
// bursts of idling on both sides, one long output hold-off, one full drain
// and a calm tail.
// ----------------------------------------------------------------------------

class text_scoreboard;
  bit [6:0] char_queue[$];
  bit       last_queue[$];
  int       errors;

  // Builds the decimal text of one accepted request, most significant first.
  function void note_request(logic [31:0] value);
    bit [31:0] magnitude;
    bit [3:0]  digits[$];
    bit        negative;
    negative  = value[31];
    // Two's-complement negation in 32 unsigned bits also covers the most
    // negative value, whose magnitude is 2**31.
    magnitude = negative ? (~value + 32'd1) : value;
    do begin
      digits.push_front(4'(magnitude % 32'd10));
      magnitude = magnitude / 32'd10;
    end while (magnitude != 0);
    if (negative) begin
      char_queue.push_back(sidta_pkg::CHAR_MINUS);
      last_queue.push_back(1'b0);
    end
    foreach (digits[i]) begin
      char_queue.push_back(sidta_pkg::CHAR_ZERO + 7'(digits[i]));
      last_queue.push_back(i == digits.size() - 1);
    end
  endfunction

  function void check_result(logic [6:0] character, logic last);
    bit [6:0] want_char;
    bit       want_last;
    if (char_queue.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected character %0d last %0b at %0t", character, last, $realtime);
      return;
    end
    want_char = char_queue.pop_front();
    want_last = last_queue.pop_front();
    if (character !== want_char || last !== want_last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch at %0t: expected char %0d last %0b, got char %0d last %0b",
                 $realtime, want_char, want_last, character, last);
    end
  endfunction

  function int pending();
    return char_queue.size();
  endfunction
endclass

module testbench;
  localparam int VALUE_BITS   = 32;
  localparam int RANDOM_ITEMS = 260;
  localparam int CALM_ITEMS   = 40;
  localparam int HOLD_START   = 60;
  localparam int HOLD_ITEMS   = 10;
  localparam int DRAIN_AT     = 150;
  localparam int HOLD_LEN     = 400;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 400000;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [VALUE_BITS-1:0] in_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [sidta_pkg::CHAR_W-1:0] out_character;
  logic                         out_last;

  text_scoreboard board = new();

  int unsigned cycle_count = 0;
  int          hold_cycles = 0;
  int          stall_cycles = 0;
  bit          calm = 1'b0;

  logic [31:0] directed_values [0:19] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, -32'sd1000000000,
    32'd999999999, 32'd1234567890, -32'sd1234567890, 32'h5555_5555,
    32'hAAAA_AAAA, 32'd7
  };

  always #4 clk = ~clk;

  signed_int_to_decimal_ascii_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_character, out_last);
  end

  // Output side: a long hold-off when requested, otherwise random stall bursts.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else if (stall_cycles > 0) begin
        out_ready = 1'b0;
        stall_cycles--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        stall_cycles = $urandom_range(1, 10) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_value(input logic [31:0] value);
    @(negedge clk);
    in_value = value;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_request(value);
  endtask

  task automatic input_gap(input int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] magnitude;
    int unsigned ndig;
    int unsigned lo;
    int unsigned hi;
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: begin
        // Uniform over the digit count, so that short texts are common.
        ndig = $urandom_range(1, 10);
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = (ndig == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
        magnitude = $urandom_range(hi, lo);
        return $urandom_range(0, 1) ? -magnitude : magnitude;
      end
      2: begin
        magnitude = $urandom_range(0, 20);
        return $urandom_range(0, 1) ? -magnitude : magnitude;
      end
      default: begin
        if ($urandom_range(0, 1))
          return 32'h8000_0000 + $urandom_range(0, 15);
        return 32'h7FFF_FFFF - $urandom_range(0, 15);
      end
    endcase
  endfunction

  initial begin
    bit quiet_in;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
      if ($urandom_range(0, 2) == 0)
        input_gap($urandom_range(1, 10));
    end
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // The output is held off while requests keep coming, so the core
      // cannot finish its current text and has to stall its input.
      if (i == HOLD_START)
        hold_cycles = HOLD_LEN;
      if (i == DRAIN_AT)
        wait_drained();
      if (i == RANDOM_ITEMS - CALM_ITEMS)
        calm = 1'b1;
      send_value(random_value());
      quiet_in = calm || (i >= HOLD_START && i < HOLD_START + HOLD_ITEMS);
      if (!quiet_in && $urandom_range(0, 3) == 0)
        input_gap($urandom_range(1, 10));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      $display("%0d expected characters never arrived", board.pending());
    if (board.errors == 0 && board.pending() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end
endmodule
